FILE: rtl/hehs_pkg.sv
// Shared types, constants and the arctangent table for the heading error scaler.
// Depends on nothing; every other file of the block imports it.
package hehs_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_LEN     = 24;
   // The vector datapath holds 34-bit inputs plus CORDIC gain and rotation growth.
   localparam int VEC_W        = 38;
   localparam int ANG_W        = 32;
   localparam int SHIFT_W      = 5;
   localparam int REQ_W        = 264;
   localparam int RSP_W        = 16;
   localparam int STRENGTH_W   = 9;

   localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;

   typedef struct packed {
      logic                     valid;
      logic                     missing;    // pose or path absent: result is zero
      logic                     yaw_zero;   // gimbal lock or null vector
      logic                     bear_zero;  // target at the current position
      logic signed [VEC_W-1:0]  yaw_x;
      logic signed [VEC_W-1:0]  yaw_y;
      logic [ANG_W-1:0]         yaw_z;
      logic signed [VEC_W-1:0]  bear_x;
      logic signed [VEC_W-1:0]  bear_y;
      logic [ANG_W-1:0]         bear_z;
   } cordic_type;

   function automatic logic [ANG_W-1:0] atan_angle(input int idx);
      logic [ANG_W-1:0] a;
      begin
         case (idx)
            0:  a = 32'h20000000;  1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;  3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;  5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;  7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;  9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;  11: a = 32'h000517CC;
            12: a = 32'h00028BE6;  13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;  15: a = 32'h0000517D;
            16: a = 32'h000028BE;  17: a = 32'h0000145F;
            18: a = 32'h00000A30;  19: a = 32'h00000518;
            20: a = 32'h0000028C;  21: a = 32'h00000146;
            22: a = 32'h000000A3;  23: a = 32'h00000051;
            default: a = '0;
         endcase
         return a;
      end
   endfunction

endpackage

FILE: rtl/heading_error_haptic_scaler.sv
// Heading error haptic scaler top level: front end, a row of CORDIC cells and
// the output scaling register. Depends on hehs_pkg, hehs_front and hehs_cell.
//
// Use: one request beat carries a pose and up to two waypoints on req_tdata;
// one response beat carries the signed haptic strength on rsp_tdata.
// Request fields from bit 0: have_pose, path_count, pos_x, pos_y, quat_x,
// quat_y, quat_z, quat_w, first_wp_x, first_wp_y, second_wp_x, second_wp_y.
// A request beat passes three front-end stages, one cell per CORDIC step and
// the output register before its response is valid.
// Throughput is one beat per cycle; every stage of the cell row advances
// together, so a new beat enters each cycle while the result register is
// empty or being taken.
// Reset empties every stage and the output register. While the receiver holds
// rsp_tready low with a result waiting, the whole row holds and req_tready is
// low; nothing is lost or repeated.
module heading_error_haptic_scaler (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [hehs_pkg::REQ_W-1:0] req_tdata,  // fields as listed above
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [hehs_pkg::RSP_W-1:0] rsp_tdata   // haptic_strength[8:0], zeros
);
   import hehs_pkg::*;

   logic       en;
   cordic_type chain [0:CORDIC_STEPS];

   logic [ANG_W-1:0]           yaw, bearing, diff;
   logic signed [40:0]         prod, biased;
   logic signed [40:0]         scaled;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STRENGTH_W-1:0]      strength_ff, strength_in;

   assign en         = ~rsp_valid_ff | rsp_tready;
   assign req_tready = en;

   hehs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_data  (req_tdata),
      .out_data (chain[0])
   );

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      hehs_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .shift (SHIFT_W'(i)),
         .angle (atan_angle(i)),
         .d_in  (chain[i]),
         .d_out (chain[i+1])
      );
   end

   // Strength is trunc(error * 255 / 2^31); negatives are biased before the shift.
   always_comb begin
      yaw     = chain[CORDIC_STEPS].yaw_zero  ? '0 : chain[CORDIC_STEPS].yaw_z;
      bearing = chain[CORDIC_STEPS].bear_zero ? '0 : chain[CORDIC_STEPS].bear_z;
      diff    = bearing - yaw;
      prod    = (41'(signed'(diff)) <<< 8) - 41'(signed'(diff));
      biased  = (prod < 0) ? prod + 41'sh0_7FFF_FFFF : prod;
      scaled  = biased >>> 31;
      strength_in = chain[CORDIC_STEPS].missing ? '0 : scaled[STRENGTH_W-1:0];
      rsp_valid_in = en ? chain[CORDIC_STEPS].valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (en) begin
         strength_ff <= strength_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-STRENGTH_W){1'b0}}, strength_ff};

endmodule

FILE: rtl/hehs_front.sv
// Front end: quaternion products, target selection, yaw and bearing vectors
// and the quadrant pre-rotation. Three register stages. Depends on hehs_pkg.
module hehs_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [hehs_pkg::REQ_W-1:0] in_data,
   output hehs_pkg::cordic_type       out_data
);
   import hehs_pkg::*;

   logic signed [15:0] qx, qy, qz, qw;
   logic signed [31:0] px, py, tx, ty;

   logic a_valid_ff, a_missing_ff;
   logic signed [31:0] p_xz_ff, p_wy_ff, p_xy_ff, p_wz_ff, p_yy_ff, p_zz_ff;
   logic signed [32:0] dx_ff, dy_ff;

   logic b_valid_ff, b_missing_ff, b_yzero_ff, b_bzero_ff;
   logic signed [VEC_W-1:0] b_yx_ff, b_yy_ff, b_bx_ff, b_by_ff;

   logic signed [32:0] gim_half, yv_half, xv_sq;
   logic signed [33:0] gim, yv, xv;
   logic               gimbal;

   cordic_type c_ff, c_in;

   assign px = in_data[34:3];
   assign py = in_data[66:35];
   assign qx = in_data[82:67];
   assign qy = in_data[98:83];
   assign qz = in_data[114:99];
   assign qw = in_data[130:115];
   // Path count of two or three selects the second waypoint.
   assign tx = in_data[2] ? in_data[226:195] : in_data[162:131];
   assign ty = in_data[2] ? in_data[258:227] : in_data[194:163];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
      end
      if (en) begin
         a_missing_ff <= ~in_data[0] | (in_data[2:1] == 2'b00);
         p_xz_ff <= qx * qz;
         p_wy_ff <= qw * qy;
         p_xy_ff <= qx * qy;
         p_wz_ff <= qw * qz;
         p_yy_ff <= qy * qy;
         p_zz_ff <= qz * qz;
         dx_ff   <= 33'(tx) - 33'(px);
         dy_ff   <= 33'(ty) - 33'(py);
      end
   end

   always_comb begin
      gim_half = 33'(p_xz_ff) - 33'(p_wy_ff);
      yv_half  = 33'(p_xy_ff) + 33'(p_wz_ff);
      xv_sq    = 33'(p_yy_ff) + 33'(p_zz_ff);
      gim      = {gim_half, 1'b0};
      yv       = {yv_half, 1'b0};
      xv       = 34'sh0_4000_0000 - {xv_sq, 1'b0};
      gimbal   = (gim >= 34'sh0_4000_0000) || (gim <= -34'sh0_4000_0000);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
      if (en) begin
         b_missing_ff <= a_missing_ff;
         b_yzero_ff   <= gimbal || ((yv == '0) && (xv == '0));
         b_bzero_ff   <= (dx_ff == '0) && (dy_ff == '0);
         b_yx_ff      <= VEC_W'(xv);
         b_yy_ff      <= VEC_W'(yv);
         b_bx_ff      <= VEC_W'(dx_ff);
         b_by_ff      <= VEC_W'(dy_ff);
      end
   end

   // A vector in the left half plane is turned by a quarter turn first.
   always_comb begin
      c_in           = '0;
      c_in.valid     = b_valid_ff;
      c_in.missing   = b_missing_ff;
      c_in.yaw_zero  = b_yzero_ff;
      c_in.bear_zero = b_bzero_ff;
      c_in.yaw_x     = b_yx_ff;
      c_in.yaw_y     = b_yy_ff;
      c_in.bear_x    = b_bx_ff;
      c_in.bear_y    = b_by_ff;
      if (b_yx_ff < 0) begin
         if (b_yy_ff >= 0) begin
            c_in.yaw_x = b_yy_ff;
            c_in.yaw_y = -b_yx_ff;
            c_in.yaw_z = QUARTER_TURN;
         end else begin
            c_in.yaw_x = -b_yy_ff;
            c_in.yaw_y = b_yx_ff;
            c_in.yaw_z = -QUARTER_TURN;
         end
      end
      if (b_bx_ff < 0) begin
         if (b_by_ff >= 0) begin
            c_in.bear_x = b_by_ff;
            c_in.bear_y = -b_bx_ff;
            c_in.bear_z = QUARTER_TURN;
         end else begin
            c_in.bear_x = -b_by_ff;
            c_in.bear_y = b_bx_ff;
            c_in.bear_z = -QUARTER_TURN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff.valid <= 1'b0;
      end else if (en) begin
         c_ff.valid <= c_in.valid;
      end
      if (en) begin
         c_ff.missing   <= c_in.missing;
         c_ff.yaw_zero  <= c_in.yaw_zero;
         c_ff.bear_zero <= c_in.bear_zero;
         c_ff.yaw_x     <= c_in.yaw_x;
         c_ff.yaw_y     <= c_in.yaw_y;
         c_ff.yaw_z     <= c_in.yaw_z;
         c_ff.bear_x    <= c_in.bear_x;
         c_ff.bear_y    <= c_in.bear_y;
         c_ff.bear_z    <= c_in.bear_z;
      end
   end

   assign out_data = c_ff;

endmodule

FILE: rtl/hehs_cell.sv
// One CORDIC vectoring step, applied to the yaw and the bearing vectors side by
// side, with its own output register. Depends on hehs_pkg.
module hehs_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic [hehs_pkg::SHIFT_W-1:0] shift,
   input  logic [hehs_pkg::ANG_W-1:0]   angle,
   input  hehs_pkg::cordic_type         d_in,
   output hehs_pkg::cordic_type         d_out
);
   import hehs_pkg::*;

   cordic_type step_in, step_ff;

   always_comb begin
      step_in = d_in;
      if (d_in.yaw_y >= 0) begin
         step_in.yaw_x = d_in.yaw_x + (d_in.yaw_y >>> shift);
         step_in.yaw_y = d_in.yaw_y - (d_in.yaw_x >>> shift);
         step_in.yaw_z = d_in.yaw_z + angle;
      end else begin
         step_in.yaw_x = d_in.yaw_x - (d_in.yaw_y >>> shift);
         step_in.yaw_y = d_in.yaw_y + (d_in.yaw_x >>> shift);
         step_in.yaw_z = d_in.yaw_z - angle;
      end
      if (d_in.bear_y >= 0) begin
         step_in.bear_x = d_in.bear_x + (d_in.bear_y >>> shift);
         step_in.bear_y = d_in.bear_y - (d_in.bear_x >>> shift);
         step_in.bear_z = d_in.bear_z + angle;
      end else begin
         step_in.bear_x = d_in.bear_x - (d_in.bear_y >>> shift);
         step_in.bear_y = d_in.bear_y + (d_in.bear_x >>> shift);
         step_in.bear_z = d_in.bear_z - angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff.valid <= 1'b0;
      end else if (en) begin
         step_ff.valid <= step_in.valid;
      end
      if (en) begin
         step_ff.missing   <= step_in.missing;
         step_ff.yaw_zero  <= step_in.yaw_zero;
         step_ff.bear_zero <= step_in.bear_zero;
         step_ff.yaw_x     <= step_in.yaw_x;
         step_ff.yaw_y     <= step_in.yaw_y;
         step_ff.yaw_z     <= step_in.yaw_z;
         step_ff.bear_x    <= step_in.bear_x;
         step_ff.bear_y    <= step_in.bear_y;
         step_ff.bear_z    <= step_in.bear_z;
      end
   end

   assign d_out = step_ff;

endmodule

FILE: dv/hehs_checker.sv
`timescale 1ns / 100ps
// Checker for the heading error haptic scaler: it watches both stream channels,
// predicts the haptic strength of each request beat and compares the responses.
// Depends on hehs_pkg for the channel widths and CORDIC constants.
module hehs_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [hehs_pkg::REQ_W-1:0] req_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [hehs_pkg::RSP_W-1:0] rsp_tdata,
   output int                         mismatch_count,
   output int                         strength_pending
);
   import hehs_pkg::*;

   localparam longint ONE_Q30 = 64'sd1 << 30;

   typedef struct packed {
      logic signed [31:0] second_wp_y;
      logic signed [31:0] second_wp_x;
      logic signed [31:0] first_wp_y;
      logic signed [31:0] first_wp_x;
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_x;
      logic [1:0]         path_count;
      logic               have_pose;
   } pose_beat_type;

   logic [RSP_W-1:0] strength_queue[$];

   // Vectoring CORDIC; >>> on a signed longint floors, as the datapath does.
   function automatic logic [ANG_W-1:0] vector_angle(longint y, longint x);
      logic [ANG_W-1:0] z;
      longint t, xs, ys;
      z = '0;
      if (x == 0 && y == 0) return '0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = QUARTER_TURN;
         end else begin
            x = -y; y = t; z = -QUARTER_TURN;
         end
      end
      for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + atan_angle(i);
         end else begin
            x = x - ys; y = y + xs; z = z - atan_angle(i);
         end
      end
      return z;
   endfunction

   function automatic logic [RSP_W-1:0] predict_strength(pose_beat_type b);
      longint qx, qy, qz, qw, tx, ty, tilt, err, strength;
      logic [ANG_W-1:0] yaw, bearing, diff;
      if (!b.have_pose || b.path_count == 2'd0) return '0;
      if (b.path_count >= 2'd2) begin
         tx = b.second_wp_x; ty = b.second_wp_y;
      end else begin
         tx = b.first_wp_x; ty = b.first_wp_y;
      end
      qx = b.quat_x; qy = b.quat_y; qz = b.quat_z; qw = b.quat_w;
      tilt = 2 * (qx * qz - qw * qy);
      if (tilt < 0) tilt = -tilt;
      if (tilt >= ONE_Q30) yaw = '0;
      else yaw = vector_angle(2 * (qx * qy + qw * qz), ONE_Q30 - 2 * (qy * qy + qz * qz));
      bearing = vector_angle(ty - longint'(b.pos_y), tx - longint'(b.pos_x));
      diff = bearing - yaw;
      err = longint'(signed'(diff));
      strength = (err * 255) / (64'sd1 << 31);
      return {{(RSP_W - STRENGTH_W){1'b0}}, strength[STRENGTH_W-1:0]};
   endfunction

   assign strength_pending = strength_queue.size();

   always @(posedge clock) begin
      logic [RSP_W-1:0] want;
      if (reset) begin
         mismatch_count <= 0;
         strength_queue.delete();
      end else begin
         if (req_tvalid && req_tready)
            strength_queue.push_back(predict_strength(pose_beat_type'(req_tdata[258:0])));
         if (rsp_tvalid && rsp_tready) begin
            if (strength_queue.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: response beat %h with nothing expected", $realtime, rsp_tdata);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = strength_queue.pop_front();
               if (want !== rsp_tdata) begin
                  if (mismatch_count < 10)
                     $display("%0t: haptic_strength expected %0d (%h), got %0d (%h)", $realtime,
                              $signed(want[STRENGTH_W-1:0]), want,
                              $signed(rsp_tdata[STRENGTH_W-1:0]), rsp_tdata);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end

endmodule

FILE: dv/tb_heading_error_haptic_scaler.sv
`timescale 1ns / 100ps
// Top of the heading error haptic scaler testbench: clock, reset, request
// stimulus, response back-pressure and the verdict. Depends on hehs_pkg,
// hehs_checker and the block itself.
module tb_heading_error_haptic_scaler;
   import hehs_pkg::*;

   localparam int RANDOM_BEATS = 1030;
   localparam int IDLE_LIMIT   = 5000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   int               mismatch_count;
   int               strength_pending;
   int               beats_sent = 0;
   int               idle_cycles = 0;

   always #5 clock = ~clock;

   heading_error_haptic_scaler u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   hehs_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .mismatch_count(mismatch_count), .strength_pending(strength_pending)
   );

   function automatic logic [REQ_W-1:0] pack_pose(logic have, logic [1:0] count,
         logic [31:0] px, logic [31:0] py, logic [15:0] qx, logic [15:0] qy,
         logic [15:0] qz, logic [15:0] qw, logic [31:0] ax, logic [31:0] ay,
         logic [31:0] bx, logic [31:0] by);
      return {5'b0, by, bx, ay, ax, qw, qz, qy, qx, py, px, count, have};
   endfunction

   // Offers one beat and returns once it is taken; valid at times drops for a random gap first.
   task automatic offer_beat(logic [REQ_W-1:0] beat);
      int gap;
      if ($urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 4000)) - 2000);
      endcase
   endfunction

   function automatic logic [REQ_W-1:0] rand_pose();
      logic [31:0] px, py;
      logic [15:0] q[4];
      logic [1:0]  count;
      px = rand_coord();
      py = rand_coord();
      foreach (q[i]) q[i] = $urandom();
      // A yaw-only quaternion keeps clear of gimbal lock most of the time.
      if ($urandom_range(0, 1)) begin
         q[0] = 16'($signed($urandom_range(0, 600)) - 300);
         q[1] = 16'($signed($urandom_range(0, 600)) - 300);
      end
      count = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
      return pack_pose($urandom_range(0, 15) != 0, count, px, py, q[0], q[1], q[2], q[3],
                       $urandom_range(0, 5) == 0 ? px : rand_coord(),
                       $urandom_range(0, 5) == 0 ? py : rand_coord(),
                       $urandom_range(0, 5) == 0 ? px : rand_coord(),
                       $urandom_range(0, 5) == 0 ? py : rand_coord());
   endfunction

   // Receiver: random stalls, one long hold-off while requests keep coming.
   initial begin
      int stall;
      bit held;
      held = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!held && beats_sent >= 300) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (250) @(posedge clock);
         end
         if ((beats_sent / 128) % 2 == 1) begin
            rsp_tready <= 1'b1;
         end else begin
            stall = $urandom_range(0, 9);
            rsp_tready <= (stall > 2);
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats: missing inputs, each path count, field extremes,
      // gimbal lock, null vectors and a target straight behind.
      offer_beat(pack_pose(1'b0, 2'd2, 0, 0, 0, 0, 0, 16'h7FFF, 100, 200, 300, 400));
      offer_beat(pack_pose(1'b1, 2'd0, 0, 0, 0, 0, 0, 16'h7FFF, 100, 200, 300, 400));
      offer_beat(pack_pose(1'b1, 2'd1, 0, 0, 0, 0, 0, 16'h7FFF, 100, 200, 300, 400));
      offer_beat(pack_pose(1'b1, 2'd2, 0, 0, 0, 0, 0, 16'h7FFF, 100, 200, 300, 400));
      offer_beat(pack_pose(1'b1, 2'd3, 0, 0, 0, 0, 0, 16'h7FFF, 100, 200, 300, 400));
      offer_beat(pack_pose(1'b1, 2'd1, 32'h8000_0000, 32'h8000_0000, 16'h7FFF, 16'h7FFF,
                           16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
      offer_beat(pack_pose(1'b1, 2'd2, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 16'h8000,
                           16'h8000, 16'h8000, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
      offer_beat(pack_pose(1'b1, 2'd1, 32'h7FFF_FFFF, 0, 0, 0, 0, 16'h7FFF,
                           32'h8000_0000, 0, 0, 0));
      offer_beat(pack_pose(1'b1, 2'd1, 0, 0, 0, 16'h8000, 0, 16'h7FFF, 500, 700, 0, 0));
      offer_beat(pack_pose(1'b1, 2'd1, 0, 0, 16'h5A82, 0, 16'h5A82, 0, 500, 700, 0, 0));
      offer_beat(pack_pose(1'b1, 2'd1, 0, 0, 0, 16'h4000, 16'h4000, 0, 500, 700, 0, 0));
      offer_beat(pack_pose(1'b1, 2'd1, 0, 0, 0, 0, 0, 0, 500, 700, 0, 0));
      offer_beat(pack_pose(1'b1, 2'd2, 1234, -5678, 0, 0, 16'h4000, 16'h4000,
                           0, 0, 1234, -5678));
      offer_beat(pack_pose(1'b1, 2'd1, 0, 0, 0, 0, 0, 16'h7FFF, -1000, 0, 0, 0));
      offer_beat(pack_pose(1'b1, 2'd1, 0, 0, 0, 0, 16'h7FFF, 0, 1000, 0, 0, 0));
      offer_beat(pack_pose(1'b1, 2'd1, 0, 0, 0, 0, 0, 16'h7FFF, 0, -1000, 0, 0));
      offer_beat(pack_pose(1'b1, 2'd3, 5, 5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           5, 5, 5, 4));

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         // Once, hold back until the pipeline has drained completely.
         if (n == 700) begin
            req_tvalid <= 1'b0;
            while (strength_pending != 0) @(posedge clock);
         end
         offer_beat(rand_pose());
      end
      req_tvalid <= 1'b0;

      while (strength_pending != 0) @(posedge clock);
      repeat (2 * (CORDIC_STEPS + 4)) @(posedge clock);
      if (mismatch_count == 0 && strength_pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: heading_error_haptic_scaler.f
rtl/hehs_pkg.sv
rtl/hehs_front.sv
rtl/hehs_cell.sv
rtl/heading_error_haptic_scaler.sv
dv/hehs_checker.sv
dv/tb_heading_error_haptic_scaler.sv
